// ----- sv/ldseg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldseg_pkg
// Shared types and codes of the data segmenter: item classes, status and
// segment type codes, register indexes, and the structs passed between parts.
// ----------------------------------------------------------------------------
package ldseg_pkg;

   // register indexes of the configuration port
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RED_LENGTH        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_LENGTH      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_SEGMENT_BYTES = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHECKPOINT_PERIOD = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_SERIAL      = 3'd4;

   // register reset values
   localparam logic [15:0] MTU_RESET    = 16'd1400;
   localparam logic [63:0] SERIAL_RESET = 64'd1;

   // item classes decided by the front end
   typedef enum logic [1:0] {
      OP_PULL = 2'd0,
      OP_GAP  = 2'd1,
      OP_BAD  = 2'd2
   } ldseg_op_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_SEGMENT = 3'd0,
      ST_NOTHING = 3'd1,
      ST_QUEUED  = 3'd2,
      ST_FULL    = 3'd3,
      ST_BEYOND  = 3'd4
   } ldseg_status_type;

   // segment type codes
   typedef enum logic [2:0] {
      SEG_RED             = 3'd0,
      SEG_RED_CP          = 3'd1,
      SEG_RED_CP_EORP     = 3'd2,
      SEG_RED_CP_EORP_EOB = 3'd3,
      SEG_GREEN           = 3'd4,
      SEG_GREEN_EOB       = 3'd5
   } ldseg_seg_type;

   // one classified input item
   typedef struct packed {
      ldseg_op_type op;
      logic [31:0]  gap_begin;
      logic [31:0]  gap_end;
      logic [63:0]  report_serial;
      logic         last_gap;
   } ldseg_item_type;

   // one stored gap
   typedef struct packed {
      logic [31:0] gap_begin;
      logic [31:0] gap_end;
      logic [63:0] report_serial;
      logic        last_gap;
   } ldseg_gap_type;

   // register values and derived sizes
   typedef struct packed {
      logic [31:0] red_length;
      logic [31:0] block_length;
      logic [31:0] eff_red;
      logic [15:0] eff_mtu;
      logic [15:0] checkpoint_period;
      logic [63:0] first_serial;
   } ldseg_cfg_type;

   // strobes that reload counters on a register write
   typedef struct packed {
      logic load_period;
      logic load_serial;
   } ldseg_cfg_load_type;

endpackage

// ----- sv/ldseg_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldseg_front
// Accepts input items, classifies them as pull, gap or malformed gap, and
// holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ldseg_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [127:0]             req_tdata,  // gap_begin, gap_end, report_serial
   input  logic                     req_tuser,  // kind
   input  logic                     req_tlast,  // last_gap_of_report
   input  ldseg_pkg::ldseg_cfg_type cfg,
   output logic                     q_valid,
   output ldseg_pkg::ldseg_item_type q_item,
   input  logic                     q_pop
);

   ldseg_pkg::ldseg_item_type entry_ff [2];
   ldseg_pkg::ldseg_item_type new_item;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   // classify the incoming item
   always_comb begin
      new_item.gap_begin     = req_tdata[31:0];
      new_item.gap_end       = req_tdata[63:32];
      new_item.report_serial = req_tdata[127:64];
      new_item.last_gap      = req_tlast;
      if (!req_tuser) begin
         new_item.op = ldseg_pkg::OP_PULL;
      end else if ((req_tdata[63:32] < req_tdata[31:0]) ||
                   (req_tdata[63:32] >= cfg.eff_red)) begin
         new_item.op = ldseg_pkg::OP_BAD;
      end else begin
         new_item.op = ldseg_pkg::OP_GAP;
      end
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign q_item     = entry_ff[rd_ptr_ff];

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // hold queued items
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ----- sv/ldseg_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldseg_back
// Carries out one classified item per cycle while its result is taken: queues gaps
// in the gap memory, splits queued gaps, runs the first pass, registers the result.
// ----------------------------------------------------------------------------
module ldseg_back #(
   parameter int unsigned GAP_QUEUE_DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ldseg_pkg::ldseg_cfg_type      cfg,
   input  ldseg_pkg::ldseg_cfg_load_type cfg_load,
   input  logic                          q_valid,
   input  ldseg_pkg::ldseg_item_type     q_item,
   output logic                          q_pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // segment_offset, segment_length, segment_type, checkpoint_serial,
   // answered_report, zero fill
   output logic [183:0]                  rsp_tdata,
   output logic [2:0]                    rsp_tuser,  // status
   output logic                          rsp_tlast   // first_pass_done
);

   localparam int unsigned PTR_W = $clog2(GAP_QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(GAP_QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(GAP_QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(GAP_QUEUE_DEPTH);

   // gap memory and its registered head read
   ldseg_pkg::ldseg_gap_type gap_mem [GAP_QUEUE_DEPTH];
   ldseg_pkg::ldseg_gap_type head_ff;
   ldseg_pkg::ldseg_gap_type gap_wdata;
   logic                     gap_we;

   logic [PTR_W-1:0] gap_head_ff, gap_head_in;
   logic [PTR_W-1:0] gap_tail_ff, gap_tail_in;
   logic [CNT_W-1:0] gap_count_ff, gap_count_in;
   logic [31:0]      split_ff, split_in;
   logic             splitting_ff, splitting_in;
   logic [31:0]      fp_index_ff, fp_index_in;
   logic [15:0]      countdown_ff, countdown_in;
   logic [63:0]      serial_ff, serial_in;

   // result register
   logic                         out_valid_ff, out_valid_in;
   ldseg_pkg::ldseg_status_type  out_status_ff, out_status_in;
   logic [31:0]                  out_offset_ff, out_offset_in;
   logic [15:0]                  out_length_ff, out_length_in;
   ldseg_pkg::ldseg_seg_type     out_type_ff, out_type_in;
   logic [63:0]                  out_cps_ff, out_cps_in;
   logic [63:0]                  out_rep_ff, out_rep_in;
   logic                         out_done_ff, out_done_in;

   // gap split terms
   logic [31:0] gap_pos_raw;
   logic [31:0] gap_pos;
   logic [32:0] gap_rem;
   logic [15:0] gap_len;
   logic        gap_last_piece;
   logic [32:0] gap_stop;

   // first pass terms
   logic        fp_active;
   logic        fp_in_red;
   logic [31:0] fp_rem;
   logic [15:0] fp_len;
   logic        fp_full;
   logic [31:0] fp_next;
   logic [15:0] countdown_dec;
   logic        periodic;

   assign q_pop = q_valid && (!out_valid_ff || rsp_tready);

   // size the next gap piece
   always_comb begin
      gap_pos_raw    = splitting_ff ? split_ff : head_ff.gap_begin;
      gap_pos        = (gap_pos_raw > head_ff.gap_end) ? head_ff.gap_end : gap_pos_raw;
      gap_rem        = {1'b0, head_ff.gap_end} - {1'b0, gap_pos} + 33'd1;
      gap_last_piece = (gap_rem <= {17'd0, cfg.eff_mtu});
      gap_len        = gap_last_piece ? gap_rem[15:0] : cfg.eff_mtu;
      gap_stop       = {1'b0, gap_pos} + {17'd0, gap_len};
   end

   // size the next first-pass segment
   always_comb begin
      fp_active     = (fp_index_ff < cfg.block_length);
      fp_in_red     = (fp_index_ff < cfg.eff_red);
      fp_rem        = fp_in_red ? (cfg.eff_red - fp_index_ff)
                                : (cfg.block_length - fp_index_ff);
      fp_full       = (fp_rem <= {16'd0, cfg.eff_mtu});
      fp_len        = fp_full ? fp_rem[15:0] : cfg.eff_mtu;
      fp_next       = fp_index_ff + {16'd0, fp_len};
      countdown_dec = countdown_ff - 16'd1;
      periodic      = (cfg.checkpoint_period != 16'd0) && (countdown_dec == 16'd0);
   end

   // execute the item at the queue head
   always_comb begin
      gap_head_in   = gap_head_ff;
      gap_tail_in   = gap_tail_ff;
      gap_count_in  = gap_count_ff;
      split_in      = split_ff;
      splitting_in  = splitting_ff;
      fp_index_in   = fp_index_ff;
      countdown_in  = countdown_ff;
      serial_in     = serial_ff;
      gap_we        = 1'b0;
      gap_wdata.gap_begin     = q_item.gap_begin;
      gap_wdata.gap_end       = q_item.gap_end;
      gap_wdata.report_serial = q_item.report_serial;
      gap_wdata.last_gap      = q_item.last_gap;

      out_valid_in  = out_valid_ff && !rsp_tready;
      out_status_in = out_status_ff;
      out_offset_in = out_offset_ff;
      out_length_in = out_length_ff;
      out_type_in   = out_type_ff;
      out_cps_in    = out_cps_ff;
      out_rep_in    = out_rep_ff;
      out_done_in   = out_done_ff;

      if (q_pop) begin
         out_valid_in  = 1'b1;
         out_status_in = ldseg_pkg::ST_SEGMENT;
         out_offset_in = 32'd0;
         out_length_in = 16'd0;
         out_type_in   = ldseg_pkg::SEG_RED;
         out_cps_in    = 64'd0;
         out_rep_in    = 64'd0;
         out_done_in   = 1'b0;
         unique case (q_item.op)
            ldseg_pkg::OP_GAP: begin
               if (gap_count_ff == CNT_FULL) begin
                  out_status_in = ldseg_pkg::ST_FULL;
               end else begin
                  gap_we        = 1'b1;
                  gap_tail_in   = (gap_tail_ff == PTR_LAST) ? '0 : gap_tail_ff + 1'b1;
                  gap_count_in  = gap_count_ff + 1'b1;
                  out_status_in = ldseg_pkg::ST_QUEUED;
               end
            end
            ldseg_pkg::OP_PULL: begin
               priority if (gap_count_ff != '0) begin
                  // resend a piece of the head gap
                  out_offset_in = gap_pos;
                  out_length_in = gap_len;
                  if (gap_last_piece && head_ff.last_gap) begin
                     out_type_in = ldseg_pkg::SEG_RED_CP;
                     if (gap_stop == {1'b0, cfg.eff_red}) begin
                        out_type_in = (cfg.eff_red == cfg.block_length)
                                      ? ldseg_pkg::SEG_RED_CP_EORP_EOB
                                      : ldseg_pkg::SEG_RED_CP_EORP;
                     end
                     out_cps_in = serial_ff;
                     out_rep_in = head_ff.report_serial;
                     serial_in  = serial_ff + 64'd1;
                  end
                  if (gap_last_piece) begin
                     splitting_in = 1'b0;
                     gap_head_in  = (gap_head_ff == PTR_LAST) ? '0 : gap_head_ff + 1'b1;
                     gap_count_in = gap_count_ff - 1'b1;
                  end else begin
                     splitting_in = 1'b1;
                     split_in     = gap_stop[31:0];
                  end
               end else if (fp_active) begin
                  // next first-pass segment
                  out_offset_in = fp_index_ff;
                  out_length_in = fp_len;
                  fp_index_in   = fp_next;
                  out_done_in   = (fp_next == cfg.block_length);
                  if (fp_in_red) begin
                     if (cfg.checkpoint_period != 16'd0) begin
                        countdown_in = periodic ? cfg.checkpoint_period : countdown_dec;
                     end
                     if (fp_full) begin
                        out_type_in = (cfg.eff_red == cfg.block_length)
                                      ? ldseg_pkg::SEG_RED_CP_EORP_EOB
                                      : ldseg_pkg::SEG_RED_CP_EORP;
                     end else if (periodic) begin
                        out_type_in = ldseg_pkg::SEG_RED_CP;
                     end
                     if (fp_full || periodic) begin
                        out_cps_in = serial_ff;
                        serial_in  = serial_ff + 64'd1;
                     end
                  end else begin
                     out_type_in = fp_full ? ldseg_pkg::SEG_GREEN_EOB
                                           : ldseg_pkg::SEG_GREEN;
                  end
               end else begin
                  out_status_in = ldseg_pkg::ST_NOTHING;
               end
            end
            default: begin
               out_status_in = ldseg_pkg::ST_BEYOND;
            end
         endcase
      end

      // reload counters on a register write
      if (cfg_load.load_period) begin
         countdown_in = cfg.checkpoint_period;
      end
      if (cfg_load.load_serial) begin
         serial_in = cfg.first_serial;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_head_ff  <= '0;
         gap_tail_ff  <= '0;
         gap_count_ff <= '0;
         split_ff     <= 32'd0;
         splitting_ff <= 1'b0;
         fp_index_ff  <= 32'd0;
         countdown_ff <= 16'd0;
         serial_ff    <= ldseg_pkg::SERIAL_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         gap_head_ff  <= gap_head_in;
         gap_tail_ff  <= gap_tail_in;
         gap_count_ff <= gap_count_in;
         split_ff     <= split_in;
         splitting_ff <= splitting_in;
         fp_index_ff  <= fp_index_in;
         countdown_ff <= countdown_in;
         serial_ff    <= serial_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // hold result payload
   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_offset_ff <= out_offset_in;
      out_length_ff <= out_length_in;
      out_type_ff   <= out_type_in;
      out_cps_ff    <= out_cps_in;
      out_rep_ff    <= out_rep_in;
      out_done_ff   <= out_done_in;
   end

   // write gaps at the tail
   always_ff @(posedge clock) begin
      if (gap_we) begin
         gap_mem[gap_tail_ff] <= gap_wdata;
      end
   end

   // read the next head entry, forwarding a gap written at that address
   always_ff @(posedge clock) begin
      if (gap_we && (gap_tail_ff == gap_head_in)) begin
         head_ff <= gap_wdata;
      end else begin
         head_ff <= gap_mem[gap_head_in];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_done_ff;
   assign rsp_tdata  = {5'd0, out_rep_ff, out_cps_ff, out_type_ff,
                        out_length_ff, out_offset_ff};

endmodule

// ----- sv/ltp_data_segmenter_core.sv -----
`timescale 1ns / 1ps
// An item passes the front-end queue entry, then the back-end result register.
// Throughput: one item per cycle unless results stall, set by the back end,
// which sizes a segment from the gap memory head or the first-pass index and
// updates its counters per item. Reset is synchronous and active high: it clears
// queues and counters and loads register defaults; the gap memory is not cleared.
// ----------------------------------------------------------------------------
// ltp_data_segmenter_core
// Cuts one block into data segment descriptors: resends queued gaps first,
// then runs the first pass over the red and green parts.
// ----------------------------------------------------------------------------
module ltp_data_segmenter_core #(
   parameter int unsigned GAP_QUEUE_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // gap_begin, gap_end, report_serial
   input  logic         req_tuser,  // kind
   input  logic         req_tlast,  // last_gap_of_report
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // segment_offset, segment_length, segment_type, checkpoint_serial,
   // answered_report, zero fill
   output logic [183:0] rsp_tdata,
   output logic [2:0]   rsp_tuser,  // status
   output logic         rsp_tlast   // first_pass_done
);

   logic [31:0] red_length_ff;
   logic [31:0] block_length_ff;
   logic [15:0] mtu_ff;
   logic [15:0] period_ff;
   logic [63:0] first_serial_ff;

   ldseg_pkg::ldseg_cfg_type      cfg;
   ldseg_pkg::ldseg_cfg_load_type cfg_load;
   ldseg_pkg::ldseg_item_type     q_item;
   logic                          q_valid;
   logic                          q_pop;

   assign csr_ready = 1'b1;

   // store register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         red_length_ff   <= 32'd0;
         block_length_ff <= 32'd0;
         mtu_ff          <= ldseg_pkg::MTU_RESET;
         period_ff       <= 16'd0;
         first_serial_ff <= ldseg_pkg::SERIAL_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            ldseg_pkg::CSR_RED_LENGTH:        red_length_ff   <= csr_data[31:0];
            ldseg_pkg::CSR_BLOCK_LENGTH:      block_length_ff <= csr_data[31:0];
            ldseg_pkg::CSR_MAX_SEGMENT_BYTES: mtu_ff          <= csr_data[15:0];
            ldseg_pkg::CSR_CHECKPOINT_PERIOD: period_ff       <= csr_data[15:0];
            ldseg_pkg::CSR_FIRST_SERIAL:      first_serial_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // reload strobes are registered, so they rise in the cycle after the write and see the new value
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_load <= '0;
      end else begin
         cfg_load.load_period <= csr_valid && (csr_index == ldseg_pkg::CSR_CHECKPOINT_PERIOD);
         cfg_load.load_serial <= csr_valid && (csr_index == ldseg_pkg::CSR_FIRST_SERIAL);
      end
   end

   // derive effective sizes
   always_comb begin
      cfg.red_length        = red_length_ff;
      cfg.block_length      = block_length_ff;
      cfg.eff_red           = (red_length_ff < block_length_ff) ? red_length_ff
                                                                : block_length_ff;
      cfg.eff_mtu           = (mtu_ff == 16'd0) ? 16'd1 : mtu_ff;
      cfg.checkpoint_period = period_ff;
      cfg.first_serial      = first_serial_ff;
   end

   ldseg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .cfg        (cfg),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   ldseg_back #(
      .GAP_QUEUE_DEPTH (GAP_QUEUE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cfg_load   (cfg_load),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- sv/ldseg_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldseg_checker
// Port-level checks of the segmenter's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ldseg_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [183:0] rsp_tdata,
   input logic [2:0]   rsp_tuser,
   input logic         rsp_tlast
);

   // hold a stalled result item
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item dropped while stalled");

   // non-segment results carry only a status
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ldseg_pkg::ST_SEGMENT) |->
         (rsp_tdata == '0) && !rsp_tlast)
      else $error("non-segment result carries payload");

   // end of first pass only on an end-of-block segment
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |->
         (rsp_tdata[50:48] == ldseg_pkg::SEG_RED_CP_EORP_EOB) ||
         (rsp_tdata[50:48] == ldseg_pkg::SEG_GREEN_EOB))
      else $error("first pass done without end of block");

   // an answered report only on a red checkpoint
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[178:115] != 64'd0) |->
         (rsp_tdata[50:48] == ldseg_pkg::SEG_RED_CP) ||
         (rsp_tdata[50:48] == ldseg_pkg::SEG_RED_CP_EORP) ||
         (rsp_tdata[50:48] == ldseg_pkg::SEG_RED_CP_EORP_EOB))
      else $error("answered report on a non-checkpoint segment");

endmodule

bind ltp_data_segmenter_core ldseg_checker u_ldseg_checker (.*);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the data segmenter core. A short table of directed
// items and register writes is walked first, then random phases reprogram the
// block between bursts of gap reports, queue floods, noise and pulls. Every
// result item is checked field by field against an in-bench segmenter model.
// ----------------------------------------------------------------------------
module tb;

   localparam int unsigned GAP_DEPTH   = 16;
   localparam int unsigned ITEM_TARGET = 1373;
   localparam int unsigned STALL_LIMIT = 5000;

   // one expected or observed descriptor
   typedef struct packed {
      ldseg_pkg::ldseg_status_type status;
      logic [31:0]                 offset;
      logic [15:0]                 length;
      ldseg_pkg::ldseg_seg_type    seg;
      logic [63:0]                 cp_serial;
      logic [63:0]                 answered;
      logic                        done;
   } segment_desc_type;

   // one row of the directed table: a register write or a repeated item
   typedef struct {
      bit                          is_reg;
      logic [2:0]                  reg_index;
      logic [63:0]                 reg_data;
      ldseg_pkg::ldseg_item_type   item;
      int unsigned                 repeats;
      bit                          known;
      ldseg_pkg::ldseg_status_type exp_status;
   } plan_row_type;

   logic         clock;
   logic         reset      = 1'b1;
   logic         csr_valid  = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index  = '0;
   logic [63:0]  csr_data   = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata  = '0;
   logic         req_tuser  = 1'b0;
   logic         req_tlast  = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [183:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         rsp_tlast;

   // model registers and state
   logic [31:0]  cfg_red     = '0;
   logic [31:0]  cfg_block   = '0;
   logic [15:0]  cfg_mtu     = ldseg_pkg::MTU_RESET;
   logic [15:0]  cfg_period  = '0;
   logic [15:0]  countdown   = '0;
   logic [63:0]  next_serial = ldseg_pkg::SERIAL_RESET;
   logic [31:0]  fp_idx      = '0;
   logic [31:0]  split_pos   = '0;
   bit           splitting   = 1'b0;
   ldseg_pkg::ldseg_gap_type gap_fifo[$];

   segment_desc_type descriptor_q[$];
   plan_row_type     plan[$];

   bit          steady     = 1'b0;
   int unsigned items_sent = 0;
   int unsigned rsp_seen   = 0;
   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;
   int unsigned n_resent = 0, n_first = 0, n_cp = 0;
   int unsigned n_full = 0, n_beyond = 0, n_nothing = 0;

   ltp_data_segmenter_core #(
      .GAP_QUEUE_DEPTH(GAP_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] eff_red();
      return (cfg_red < cfg_block) ? cfg_red : cfg_block;
   endfunction

   function automatic logic [63:0] eff_mtu();
      return (cfg_mtu == 16'd0) ? 64'd1 : 64'(cfg_mtu);
   endfunction

   // mirror a register write into the model
   function automatic void apply_reg(input logic [2:0] idx, input logic [63:0] val);
      case (idx)
         ldseg_pkg::CSR_RED_LENGTH: cfg_red = val[31:0];
         ldseg_pkg::CSR_BLOCK_LENGTH: cfg_block = val[31:0];
         ldseg_pkg::CSR_MAX_SEGMENT_BYTES: cfg_mtu = val[15:0];
         ldseg_pkg::CSR_CHECKPOINT_PERIOD: begin
            cfg_period = val[15:0];
            countdown  = val[15:0];
         end
         ldseg_pkg::CSR_FIRST_SERIAL: next_serial = val;
         default: ;
      endcase
   endfunction

   // work out the descriptor an accepted item yields and advance the model
   function automatic segment_desc_type predict_descriptor(
      input ldseg_pkg::ldseg_item_type it);
      segment_desc_type         d;
      ldseg_pkg::ldseg_gap_type g;
      logic [63:0]              red, mtu, pos, len, gend;
      bit                       last_piece, eor, periodic;
      d = '0;
      red = 64'(eff_red());
      mtu = eff_mtu();
      if (it.op == ldseg_pkg::OP_GAP) begin
         if (it.gap_end < it.gap_begin || 64'(it.gap_end) >= red) begin
            d.status = ldseg_pkg::ST_BEYOND;
            n_beyond++;
         end else if (gap_fifo.size() >= GAP_DEPTH) begin
            d.status = ldseg_pkg::ST_FULL;
            n_full++;
         end else begin
            g.gap_begin     = it.gap_begin;
            g.gap_end       = it.gap_end;
            g.report_serial = it.report_serial;
            g.last_gap      = it.last_gap;
            gap_fifo.push_back(g);
            d.status = ldseg_pkg::ST_QUEUED;
         end
         return d;
      end
      // resend queued gaps before any first-pass data
      if (gap_fifo.size() > 0) begin
         g = gap_fifo[0];
         gend = 64'(g.gap_end);
         if (!splitting) begin
            split_pos = g.gap_begin;
            splitting = 1'b1;
         end
         pos = 64'(split_pos);
         if (pos > gend) pos = gend;
         len = gend - pos + 64'd1;
         if (len > mtu) len = mtu;
         last_piece = (pos + len == gend + 64'd1);
         if (last_piece && g.last_gap) begin
            d.seg = ldseg_pkg::SEG_RED_CP;
            if (pos + len == red)
               d.seg = (red == 64'(cfg_block)) ? ldseg_pkg::SEG_RED_CP_EORP_EOB
                                               : ldseg_pkg::SEG_RED_CP_EORP;
            d.cp_serial = next_serial;
            d.answered  = g.report_serial;
            next_serial++;
            n_cp++;
         end
         d.offset = pos[31:0];
         d.length = len[15:0];
         if (last_piece) begin
            splitting = 1'b0;
            void'(gap_fifo.pop_front());
         end else begin
            split_pos = 32'(pos + len);
         end
         n_resent++;
         return d;
      end
      // first pass: red part with checkpoints, then green part
      if (fp_idx < cfg_block) begin
         pos = 64'(fp_idx);
         if (pos < red) begin
            len = red - pos;
            if (len > mtu) len = mtu;
            eor = (pos + len == red);
            periodic = 1'b0;
            if (cfg_period != 16'd0) begin
               countdown = countdown - 16'd1;
               if (countdown == 16'd0) begin
                  countdown = cfg_period;
                  periodic  = 1'b1;
               end
            end
            if (eor)
               d.seg = (red == 64'(cfg_block)) ? ldseg_pkg::SEG_RED_CP_EORP_EOB
                                               : ldseg_pkg::SEG_RED_CP_EORP;
            else if (periodic)
               d.seg = ldseg_pkg::SEG_RED_CP;
            if (eor || periodic) begin
               d.cp_serial = next_serial;
               next_serial++;
               n_cp++;
            end
         end else begin
            len = 64'(cfg_block) - pos;
            if (len > mtu) len = mtu;
            d.seg = (pos + len == 64'(cfg_block)) ? ldseg_pkg::SEG_GREEN_EOB
                                                  : ldseg_pkg::SEG_GREEN;
         end
         fp_idx   = 32'(pos + len);
         d.offset = pos[31:0];
         d.length = len[15:0];
         d.done   = (fp_idx == cfg_block);
         n_first++;
      end else begin
         d.status = ldseg_pkg::ST_NOTHING;
         n_nothing++;
      end
      return d;
   endfunction

   function automatic plan_row_type reg_row(input logic [2:0] idx, input logic [63:0] val);
      plan_row_type r;
      r.is_reg     = 1'b1;
      r.reg_index  = idx;
      r.reg_data   = val;
      r.item       = '0;
      r.repeats    = 0;
      r.known      = 1'b0;
      r.exp_status = ldseg_pkg::ST_SEGMENT;
      return r;
   endfunction

   function automatic plan_row_type item_row(input ldseg_pkg::ldseg_op_type op,
                                             input logic [31:0] b,
                                             input logic [31:0] e, input logic [63:0] rep,
                                             input logic last, input int unsigned count,
                                             input bit known,
                                             input ldseg_pkg::ldseg_status_type st);
      plan_row_type r;
      r.is_reg             = 1'b0;
      r.reg_index          = '0;
      r.reg_data           = '0;
      r.item.op            = op;
      r.item.gap_begin     = b;
      r.item.gap_end       = e;
      r.item.report_serial = rep;
      r.item.last_gap      = last;
      r.repeats            = count;
      r.known              = known;
      r.exp_status         = st;
      return r;
   endfunction

   // program one register once every expected descriptor has come back
   task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
      req_tvalid <= 1'b0;
      while (descriptor_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      apply_reg(idx, val);
   endtask

   // offer one item, hold it until taken, then queue its expected descriptor
   task automatic run_item(input ldseg_pkg::ldseg_item_type it, input bit known,
                           input ldseg_pkg::ldseg_status_type st);
      segment_desc_type d;
      while (!steady && $urandom_range(0, 99) < 32) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= (it.op == ldseg_pkg::OP_GAP);
      req_tlast  <= it.last_gap;
      req_tdata  <= {it.report_serial, it.gap_end, it.gap_begin};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      steady <= (items_sent >= 500 && items_sent < 800);
      d = predict_descriptor(it);
      if (known) begin
         d = '0;
         d.status = st;
      end
      descriptor_q.push_back(d);
   endtask

   task automatic send_pull();
      ldseg_pkg::ldseg_item_type it;
      it.op            = ldseg_pkg::OP_PULL;
      it.gap_begin     = $urandom;
      it.gap_end       = $urandom;
      it.report_serial = {$urandom, $urandom};
      it.last_gap      = $urandom_range(0, 1);
      run_item(it, 1'b0, ldseg_pkg::ST_SEGMENT);
   endtask

   // gap that fits inside the current red part, when the red part is not empty
   task automatic send_report_gap(input logic last);
      ldseg_pkg::ldseg_item_type it;
      logic [31:0]               red, lim;
      red = eff_red();
      it.op            = ldseg_pkg::OP_GAP;
      it.report_serial = {$urandom, $urandom};
      it.last_gap      = last;
      if (red == 32'd0) begin
         it.gap_begin = $urandom_range(0, 15);
         it.gap_end   = it.gap_begin;
      end else begin
         it.gap_begin = $urandom_range(0, red - 32'd1);
         lim = red - 32'd1 - it.gap_begin;
         if (lim > 32'(3 * eff_mtu())) lim = 32'(3 * eff_mtu());
         if ($urandom_range(0, 3) == 0)
            it.gap_end = red - 32'd1;
         else
            it.gap_end = it.gap_begin + $urandom_range(0, lim);
      end
      run_item(it, 1'b0, ldseg_pkg::ST_SEGMENT);
   endtask

   // gap with arbitrary, mostly out-of-range or inverted bounds
   task automatic send_noise_gap();
      ldseg_pkg::ldseg_item_type it;
      it.op            = ldseg_pkg::OP_GAP;
      it.report_serial = {$urandom, $urandom};
      it.last_gap      = $urandom_range(0, 1);
      case ($urandom_range(0, 2))
         0: begin
            it.gap_begin = $urandom;
            it.gap_end   = $urandom;
         end
         1: begin
            it.gap_end   = eff_red();
            it.gap_begin = $urandom_range(0, it.gap_end);
         end
         default: begin
            it.gap_begin = $urandom_range(1, 32'hFFFF_FFFF);
            it.gap_end   = it.gap_begin - $urandom_range(1, it.gap_begin);
         end
      endcase
      run_item(it, 1'b0, ldseg_pkg::ST_SEGMENT);
   endtask

   // pick a new register setting; block and red are placed around the pass index
   task automatic reconfigure(input bit all_regs);
      logic [63:0] span;
      logic [31:0] blk, red;
      logic [15:0] val16;
      logic [63:0] serial;
      case ($urandom_range(0, 9))
         0: val16 = 16'd0;
         1: val16 = 16'hFFFF;
         2: val16 = 16'd1;
         default: val16 = $urandom_range(1, 600);
      endcase
      if (all_regs || $urandom_range(0, 2) != 0)
         write_reg(ldseg_pkg::CSR_MAX_SEGMENT_BYTES, 64'(val16));
      case ($urandom_range(0, 9))
         0: blk = 32'hFFFF_FFFF;
         1: blk = fp_idx;
         2: blk = $urandom_range(0, fp_idx);
         default: begin
            span = 64'(fp_idx) + 64'($urandom_range(1, 12)) * eff_mtu();
            blk  = (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
         end
      endcase
      case ($urandom_range(0, 9))
         0: red = 32'd0;
         1: red = 32'hFFFF_FFFF;
         2: red = blk;
         3: red = $urandom_range(0, blk);
         default: red = $urandom_range(fp_idx, blk);
      endcase
      if (all_regs || $urandom_range(0, 2) != 0) begin
         write_reg(ldseg_pkg::CSR_BLOCK_LENGTH, 64'(blk));
         write_reg(ldseg_pkg::CSR_RED_LENGTH, 64'(red));
      end
      case ($urandom_range(0, 5))
         0: val16 = 16'd0;
         1: val16 = 16'hFFFF;
         default: val16 = $urandom_range(1, 6);
      endcase
      if (all_regs || $urandom_range(0, 2) == 0)
         write_reg(ldseg_pkg::CSR_CHECKPOINT_PERIOD, 64'(val16));
      case ($urandom_range(0, 5))
         0: serial = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
         1: serial = 64'd0;
         default: serial = {$urandom, $urandom};
      endcase
      if (all_regs || $urandom_range(0, 2) == 0)
         write_reg(ldseg_pkg::CSR_FIRST_SERIAL, serial);
   endtask

   // compare one field, report the first few misses
   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t result %0d %s: expected %h, got %h",
                     $time, rsp_seen, name, want, got);
      end
   endtask

   // check a taken result against the oldest expected descriptor
   task automatic check_descriptor();
      segment_desc_type exp_d;
      rsp_seen++;
      if (descriptor_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t result %0d arrived with nothing pending, status %0d",
                     $time, rsp_seen, rsp_tuser);
      end else begin
         exp_d = descriptor_q.pop_front();
         compare_field("status", 64'(exp_d.status), 64'(rsp_tuser));
         compare_field("segment_offset", 64'(exp_d.offset), 64'(rsp_tdata[31:0]));
         compare_field("segment_length", 64'(exp_d.length), 64'(rsp_tdata[47:32]));
         compare_field("segment_type", 64'(exp_d.seg), 64'(rsp_tdata[50:48]));
         compare_field("checkpoint_serial", exp_d.cp_serial, rsp_tdata[114:51]);
         compare_field("answered_report", exp_d.answered, rsp_tdata[178:115]);
         compare_field("first_pass_done", 64'(exp_d.done), 64'(rsp_tlast));
      end
   endtask

   // result side: take items with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_descriptor();
         rsp_tready <= steady || ($urandom_range(0, 99) >= 32);
      end
   end

   // watchdog: end the run when no channel moves for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t watchdog: no item moved for %0d cycles", $time, quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      plan_row_type row;
      int unsigned  phase_end;
      int unsigned  pick;
      int unsigned  n;
      bit           first_phase;

      // directed table
      plan.push_back(item_row(ldseg_pkg::OP_PULL, 0, 0, 0, 1'b0, 1, 1'b1,
                              ldseg_pkg::ST_NOTHING));
      plan.push_back(item_row(ldseg_pkg::OP_GAP, 0, 0, 64'd5, 1'b1, 1, 1'b1,
                              ldseg_pkg::ST_BEYOND));
      plan.push_back(reg_row(ldseg_pkg::CSR_MAX_SEGMENT_BYTES, 64'd0));
      plan.push_back(reg_row(ldseg_pkg::CSR_BLOCK_LENGTH, 64'd3));
      plan.push_back(reg_row(ldseg_pkg::CSR_RED_LENGTH, 64'd5));
      plan.push_back(reg_row(ldseg_pkg::CSR_FIRST_SERIAL, 64'hFFFF_FFFF_FFFF_FFFF));
      plan.push_back(item_row(ldseg_pkg::OP_PULL, 0, 0, 0, 1'b0, 4, 1'b0,
                              ldseg_pkg::ST_SEGMENT));
      plan.push_back(item_row(ldseg_pkg::OP_GAP, 2, 2, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1,
                              1'b1, ldseg_pkg::ST_QUEUED));
      plan.push_back(item_row(ldseg_pkg::OP_PULL, 0, 0, 0, 1'b0, 1, 1'b0,
                              ldseg_pkg::ST_SEGMENT));
      plan.push_back(reg_row(ldseg_pkg::CSR_RED_LENGTH, 64'd3000));
      plan.push_back(reg_row(ldseg_pkg::CSR_BLOCK_LENGTH, 64'd6000));
      plan.push_back(reg_row(ldseg_pkg::CSR_MAX_SEGMENT_BYTES, 64'd1000));
      plan.push_back(reg_row(ldseg_pkg::CSR_CHECKPOINT_PERIOD, 64'd2));
      plan.push_back(reg_row(ldseg_pkg::CSR_FIRST_SERIAL, 64'd100));
      plan.push_back(item_row(ldseg_pkg::OP_GAP, 10, 5, 64'd8, 1'b1, 1, 1'b1,
                              ldseg_pkg::ST_BEYOND));
      plan.push_back(item_row(ldseg_pkg::OP_GAP, 0, 3000, 64'd8, 1'b1, 1, 1'b1,
                              ldseg_pkg::ST_BEYOND));
      plan.push_back(item_row(ldseg_pkg::OP_GAP, 0, 32'hFFFF_FFFF, 64'd8, 1'b0, 1, 1'b1,
                              ldseg_pkg::ST_BEYOND));
      plan.push_back(item_row(ldseg_pkg::OP_GAP, 500, 2999, 64'd9, 1'b0, 1, 1'b1,
                              ldseg_pkg::ST_QUEUED));
      plan.push_back(item_row(ldseg_pkg::OP_GAP, 1000, 1500, 64'd10, 1'b1, 1, 1'b1,
                              ldseg_pkg::ST_QUEUED));
      plan.push_back(item_row(ldseg_pkg::OP_PULL, 0, 0, 0, 1'b0, 4, 1'b0,
                              ldseg_pkg::ST_SEGMENT));
      plan.push_back(item_row(ldseg_pkg::OP_PULL, 0, 0, 0, 1'b0, 5, 1'b0,
                              ldseg_pkg::ST_SEGMENT));
      plan.push_back(reg_row(ldseg_pkg::CSR_BLOCK_LENGTH, 64'd100));
      plan.push_back(item_row(ldseg_pkg::OP_PULL, 0, 0, 0, 1'b0, 1, 1'b1,
                              ldseg_pkg::ST_NOTHING));

      // hold reset, then release it for good
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         row = plan[i];
         if (row.is_reg) begin
            write_reg(row.reg_index, row.reg_data);
         end else begin
            for (int r = 0; r < row.repeats; r++)
               run_item(row.item, row.known, row.exp_status);
         end
      end

      // random phases: new setting, then a burst of mixed sequences
      first_phase = 1'b1;
      while (items_sent < ITEM_TARGET) begin
         reconfigure(first_phase);
         first_phase = 1'b0;
         phase_end = items_sent + $urandom_range(40, 120);
         while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               // well-formed report: a few gaps, final one flagged, then pulls
               n = $urandom_range(1, 4);
               for (int k = 1; k <= n; k++) send_report_gap(k == n);
               n = $urandom_range(1, 8);
               repeat (n) send_pull();
            end else if (pick < 65) begin
               n = $urandom_range(1, 10);
               repeat (n) send_pull();
            end else if (pick < 75) begin
               // flood the gap queue past its depth
               n = $urandom_range(17, 19);
               repeat (n) send_report_gap($urandom_range(0, 1));
               n = $urandom_range(1, 20);
               repeat (n) send_pull();
            end else if (pick < 90) begin
               send_noise_gap();
            end else begin
               // broken report: unflagged gaps only
               n = $urandom_range(1, 3);
               repeat (n) send_report_gap(1'b0);
               send_pull();
            end
         end
      end

      // drain, then let the pipeline settle
      req_tvalid <= 1'b0;
      while (descriptor_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d items: %0d resent pieces, %0d first-pass segments, %0d checkpoints",
               items_sent, n_resent, n_first, n_cp);
      $display("%0d gaps refused on a full queue, %0d rejected past red, %0d empty pulls",
               n_full, n_beyond, n_nothing);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d field mismatches", mismatches);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/ldseg_pkg.sv
sv/ldseg_front.sv
sv/ldseg_back.sv
sv/ltp_data_segmenter_core.sv
sv/ldseg_checker.sv
sim/tb.sv
